FILE: rtl/sha256_stream_hasher_assert.svh
// assertion macros shared by the sha-256 stream hasher rtl
// depends on i_clk and i_rst_n being visible in the including module
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SHA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SHA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sha_pkg.sv
// shared constants, byte select codes and controller/datapath interface types
// no dependencies
package sha_pkg;

    // width of the bit length count (32..64); byte count is three bits narrower
    localparam int LENGTH_BITS = 64;
    localparam int MSG_BYTES_W = LENGTH_BITS - 3;

    // source of the byte shifted into the block register
    localparam logic [1:0] BSEL_DATA  = 2'd0;
    localparam logic [1:0] BSEL_PAD80 = 2'd1;
    localparam logic [1:0] BSEL_ZERO  = 2'd2;
    localparam logic [1:0] BSEL_LEN   = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       shift_byte;
        logic [1:0] byte_sel;
        logic [2:0] len_idx;
        logic       len_inc;
        logic       len_clear;
        logic       load_vars;
        logic       round_en;
        logic [5:0] round;
        logic       hash_fold;
        logic       hash_init;
        logic       out_load;
        logic [2:0] out_idx;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/sha_ctrl.sv
// sequencing controller: byte intake, padding, round count and digest output
// depends on sha_pkg and sha256_stream_hasher_assert.svh
`include "sha256_stream_hasher_assert.svh"

module sha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_has_byte,
    input  logic              i_last,
    output logic              o_in_ready,
    output sha_pkg::t_dp_cmd  o_cmd,
    input  sha_pkg::t_dp_stat i_stat
);
    import sha_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [5:0] r_fill, n_fill;
    logic [5:0] r_round, n_round;
    logic [2:0] r_emit, n_emit;
    logic       r_fin, n_fin;
    logic       r_first, n_first;
    logic       r_lenok, n_lenok;
    logic       r_final, n_final;
    logic       w_lenok_now;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_round <= '0;
            r_emit  <= '0;
            r_fin   <= 1'b0;
            r_first <= 1'b0;
            r_lenok <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_round <= n_round;
            r_emit  <= n_emit;
            r_fin   <= n_fin;
            r_first <= n_first;
            r_lenok <= n_lenok;
            r_final <= n_final;
        end
    end

    // length goes in this block if the 0x80 marker lands before byte 56
    assign w_lenok_now = r_first ? (r_fill < LEN_START) : r_lenok;

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_round    = r_round;
        n_emit     = r_emit;
        n_fin      = r_fin;
        n_first    = r_first;
        n_lenok    = r_lenok;
        n_final    = r_final;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_has_byte) begin
                        o_cmd.shift_byte = 1'b1;
                        o_cmd.byte_sel   = BSEL_DATA;
                        o_cmd.len_inc    = 1'b1;
                        n_fill           = r_fill + 6'd1;
                        if (r_fill == LAST_BYTE) begin
                            o_cmd.load_vars = 1'b1;
                            n_round         = '0;
                            n_state         = ST_COMP;
                        end
                    end
                    if (i_last) begin
                        n_fin   = 1'b1;
                        n_first = 1'b1;
                        n_lenok = 1'b0;
                        if (!(i_has_byte && r_fill == LAST_BYTE)) begin
                            n_state = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD: begin
                o_cmd.shift_byte = 1'b1;
                o_cmd.len_idx    = r_fill[2:0];
                if (r_first) begin
                    o_cmd.byte_sel = BSEL_PAD80;
                end else if (r_lenok && r_fill >= LEN_START) begin
                    o_cmd.byte_sel = BSEL_LEN;
                end else begin
                    o_cmd.byte_sel = BSEL_ZERO;
                end
                n_first = 1'b0;
                n_fill  = r_fill + 6'd1;
                if (r_fill == LAST_BYTE) begin
                    o_cmd.load_vars = 1'b1;
                    n_round         = '0;
                    n_final         = w_lenok_now;
                    n_lenok         = 1'b1;
                    n_state         = ST_COMP;
                end else begin
                    n_lenok = w_lenok_now;
                end
            end
            ST_COMP: begin
                o_cmd.round_en = 1'b1;
                o_cmd.round    = r_round;
                n_round        = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                o_cmd.hash_fold = 1'b1;
                if (r_final) begin
                    n_emit  = '0;
                    n_state = ST_EMIT;
                end else if (r_fin) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_idx  = r_emit;
                    n_emit         = r_emit + 3'd1;
                    if (r_emit == LAST_WORD) begin
                        o_cmd.hash_init = 1'b1;
                        o_cmd.len_clear = 1'b1;
                        n_fin           = 1'b0;
                        n_final         = 1'b0;
                        n_state         = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // a block compression always starts at round zero and ends in the fold
    `SHA_ASSERT_NEXT(a_round_start, o_cmd.load_vars, (r_state == ST_COMP && r_round == '0), "compression did not start at round zero")
    `SHA_ASSERT_NEXT(a_round_end, (r_state == ST_COMP && r_round == LAST_ROUND), (r_state == ST_FOLD), "last round not followed by fold")
    `SHA_ASSERT_NOW(a_emit_aligned, (r_state == ST_EMIT), (r_fill == '0), "digest output with a partial block")
    `SHA_ASSERT_NOW(a_final_in_pad, r_final, r_fin, "final block flagged outside padding")

endmodule

FILE: rtl/sha_dp.sv
// datapath: block/schedule shift register, round unit, hash state, output register
// depends on sha_pkg
module sha_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_data_byte,
    input  sha_pkg::t_dp_cmd  i_cmd,
    output sha_pkg::t_dp_stat o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [31:0]       o_out_data,
    output logic [2:0]        o_out_idx,
    output logic              o_out_last
);
    import sha_pkg::*;

    localparam logic [2:0] LAST_WORD = 3'd7;

    // round constants
    function automatic logic [31:0] k_const(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    // initial hash values
    function automatic logic [31:0] iv_const(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [511:0]           r_blk;
    logic [31:0]            r_v [8];
    logic [31:0]            r_hash [8];
    logic [MSG_BYTES_W-1:0] r_len;
    logic                   r_out_valid;
    logic [31:0]            r_out_data;
    logic [2:0]             r_out_idx;
    logic                   r_out_last;

    logic [31:0] w_win0, w_win1, w_win9, w_win14, w_wnext;
    logic [31:0] w_s1, w_ch, w_t1, w_s0, w_maj, w_t2;
    logic [63:0] w_bits;
    logic [63:0] w_bits_sh;
    logic [7:0]  w_byte;

    // schedule taps: word 0 is the oldest word of the window
    assign w_win0  = r_blk[511:480];
    assign w_win1  = r_blk[479:448];
    assign w_win9  = r_blk[223:192];
    assign w_win14 = r_blk[63:32];
    assign w_wnext = w_win0 + (rotr(w_win1, 7) ^ rotr(w_win1, 18) ^ (w_win1 >> 3))
                   + w_win9 + (rotr(w_win14, 17) ^ rotr(w_win14, 19) ^ (w_win14 >> 10));

    // one compression round
    assign w_s1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_t1  = r_v[7] + w_s1 + w_ch + k_const(i_cmd.round) + w_win0;
    assign w_s0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t2  = w_s0 + w_maj;

    // big-endian bit length, byte picked by its position in the last 8 bytes
    assign w_bits    = 64'({r_len, 3'b000});
    assign w_bits_sh = w_bits >> {~i_cmd.len_idx, 3'b000};

    // byte source
    always_comb begin
        case (i_cmd.byte_sel)
            BSEL_DATA:  w_byte = i_data_byte;
            BSEL_PAD80: w_byte = 8'h80;
            BSEL_ZERO:  w_byte = 8'h00;
            BSEL_LEN:   w_byte = w_bits_sh[7:0];
            default:    w_byte = 8'h00;
        endcase
    end

    // block register: bytes shift in, then doubles as the schedule window
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_byte) begin
            r_blk <= {r_blk[503:0], w_byte};
        end else if (i_cmd.round_en) begin
            r_blk <= {r_blk[479:0], w_wnext};
        end
    end

    // working variables a..h
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vars) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_hash[i];
            end
        end else if (i_cmd.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    // hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.hash_init) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= iv_const(3'(i));
            end
        end else if (i_cmd.hash_fold) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= r_hash[i] + r_v[i];
            end
        end
    end

    // saturating message byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.len_clear) begin
            r_len <= '0;
        end else if (i_cmd.len_inc && r_len != '1) begin
            r_len <= r_len + 1'b1;
        end
    end

    // digest output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_hash[i_cmd.out_idx];
            r_out_idx  <= i_cmd.out_idx;
            r_out_last <= (i_cmd.out_idx == LAST_WORD);
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_out_idx       = r_out_idx;
    assign o_out_last      = r_out_last;

endmodule

FILE: rtl/sha256_stream_hasher.sv
// top level of the streaming sha-256 hasher
// depends on sha_pkg, sha_ctrl and sha_dp
//
// usage:
//   s_axis carries the message one byte per transfer: tdata is the byte,
//   tuser[0] says the byte is present, tlast ends the message. A transfer
//   with tlast and no byte finishes the message (empty messages hash too);
//   a transfer with neither byte nor tlast is dropped.
//   m_axis returns the digest as eight 32-bit transfers, word 0 first;
//   tuser is the word index and tlast marks word 7.
// timing:
//   bytes are taken one per cycle while s_axis_tready is high; the 64th
//   byte of a block starts a compression (one round per cycle in a single
//   round unit, then the fold into the hash state), during which
//   s_axis_tready is low. On tlast the padding is shifted in one byte per
//   cycle up to the block end (one or two blocks, each followed by a
//   compression), then the digest words leave through a single output
//   register, one per cycle while m_axis_tready is high.
// reset and stall:
//   reset loads the initial hash values and clears the byte count.
//   A stalled m_axis holds the output register and the digest sequencing;
//   the next message is taken while the last digest word still waits.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);
    import sha_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencing
    sha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_has_byte (s_axis_tuser[0]),
        .i_last     (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // hashing datapath
    sha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_idx   (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule
